// ----- hw/rtl/rcfp_pkg.sv -----
// Shared types and constants of the serial RC frame parser.
// No dependencies; every module of the parser imports this package.
package rcfp_pkg;

    // Frame layout
    localparam int          FRAME_LEN   = 32;
    localparam int          SUM_LEN     = 30;
    localparam int          POS_W       = 5;
    localparam logic [4:0]  SUM_LO_POS  = 5'd30;
    localparam logic [4:0]  LAST_POS    = 5'd31;
    localparam logic [4:0]  CH_BASE     = 5'd2;
    localparam logic [7:0]  HDR0        = 8'h20;
    localparam logic [7:0]  HDR1        = 8'h40;
    localparam logic [15:0] SUM_INIT    = 16'hFFFF;
    localparam logic [15:0] CH_MIN      = 16'd900;
    localparam logic [15:0] CH_MAX      = 16'd2100;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

    // Input request kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CHANNEL  = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_FAILSAFE = 2'd2
    } status_t;

    // One result request
    typedef struct packed {
        status_t     status;
        logic [3:0]  channel_index;
        logic [11:0] channel_value;
        logic        last;
        logic        signal_ok;
        logic [31:0] frames_accepted;
        logic [31:0] checksum_failures;
        logic [31:0] failsafe_events;
    } result_t;

    // Frame store write port
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    // Frame store read request for one channel (low and high byte)
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr_lo;
        logic [POS_W-1:0] addr_hi;
    } mem_rd_t;

endpackage

// ----- hw/rtl/rcfp_frame_mem.sv -----
// Frame store of the parser: 32 bytes, one write port, two registered read ports.
// Depends on rcfp_pkg for the port structs.
module rcfp_frame_mem
    import rcfp_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  mem_rd_t rd,
    output logic [7:0] rd_lo,
    output logic [7:0] rd_hi
);

    logic [7:0] store [FRAME_LEN];
    logic [7:0] rd_lo_reg;
    logic [7:0] rd_hi_reg;

    // Byte write from the receive path.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store[wr.addr] <= wr.data;
        end
    end

    // Both bytes of one channel are read together; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_lo_reg <= store[rd.addr_lo];
            rd_hi_reg <= store[rd.addr_hi];
        end
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

endmodule

// ----- hw/rtl/rcfp_out_stage.sv -----
// Output register of the parser: holds one result request until the sink takes it.
// Depends on rcfp_pkg for the result type.
module rcfp_out_stage
    import rcfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    ready,
    output logic    valid,
    output result_t data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // A new result is only loaded when the slot is empty or being emptied.
    assign valid_next = load | (valid_reg & ~ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- hw/rtl/rc_serial_frame_parser_core.sv -----
// Serial RC frame parser. Each received byte or millisecond tick is one input request. A
// frame that completes with a good checksum is then read out of the frame store at one
// channel per cycle while the result stream is not stalled; the pace is set by the
// store's pair of read ports, which fetch both bytes of one channel at a time. No
// input is taken during readout or while the output register holds a result that is
// not being taken in the same cycle. The store needs no clearing pass after reset:
// channels are only read from a frame whose bytes were just written.
// Depends on rcfp_pkg, rcfp_frame_mem and rcfp_out_stage.
module rc_serial_frame_parser_core
    import rcfp_pkg::*;
#(
    parameter int CHANNELS = 14
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration: failsafe_timeout_ms
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic         s_axis_tuser,   // [0] opcode
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // [3:0] channel_index, [15:4] channel_value,
                                         // [16] signal_ok, [48:17] frames_accepted,
                                         // [80:49] checksum_failures,
                                         // [112:81] failsafe_events, rest zero
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    output logic         m_axis_tlast    // last result of the input request
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    localparam logic [3:0] LAST_CH = 4'(CHANNELS - 1);

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       sum_lo_reg, sum_lo_next;
    logic             sig_valid_reg, sig_valid_next;
    logic [15:0]      silence_reg, silence_next;
    logic [31:0]      accepted_reg, accepted_next;
    logic [31:0]      bad_sum_reg, bad_sum_next;
    logic [31:0]      failsafe_reg, failsafe_next;
    logic [15:0]      timeout_reg, timeout_next;
    logic [3:0]       ch_reg, ch_next;

    logic       accept;
    logic       slot_free;
    logic       out_valid;
    logic       out_load;
    result_t    out_res;
    result_t    out_data;
    mem_wr_t    mem_wr;
    mem_rd_t    mem_rd;
    logic [7:0] rd_lo;
    logic [7:0] rd_hi;
    logic [15:0] raw;
    logic [15:0] clamped;
    logic [15:0] silence_inc;

    rcfp_frame_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rd_lo (rd_lo),
        .rd_hi (rd_hi)
    );

    rcfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_res),
        .ready     (m_axis_tready),
        .valid     (out_valid),
        .data      (out_data)
    );

    // Handshake on the input side.
    assign slot_free     = ~out_valid | m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) & slot_free;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Channel value from the store, clamped to the legal pulse range.
    assign raw = {rd_hi, rd_lo};
    always_comb
    begin
        priority if (raw < CH_MIN)
        begin
            clamped = CH_MIN;
        end
        else if (raw > CH_MAX)
        begin
            clamped = CH_MAX;
        end
        else
        begin
            clamped = raw;
        end
    end

    assign silence_inc = (silence_reg == SILENCE_MAX) ? SILENCE_MAX : silence_reg + 16'd1;

    // Timeout register write.
    assign timeout_next = cfg_we ? cfg_wdata : timeout_reg;

    // Frame tracking, timers, counters and readout sequencing.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        sum_lo_next    = sum_lo_reg;
        sig_valid_next = sig_valid_reg;
        silence_next   = silence_reg;
        accepted_next  = accepted_reg;
        bad_sum_next   = bad_sum_reg;
        failsafe_next  = failsafe_reg;
        ch_next        = ch_reg;
        mem_wr         = '0;
        mem_rd         = '0;
        out_load       = 1'b0;
        out_res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == OP_TICK)
                    begin
                        // Age the silence timer; a long silence drops the signal.
                        silence_next = silence_inc;
                        if (sig_valid_reg && (silence_inc > timeout_reg))
                        begin
                            sig_valid_next = 1'b0;
                            failsafe_next  = failsafe_reg + 32'd1;
                            out_load       = 1'b1;
                            out_res.status = ST_FAILSAFE;
                            out_res.last   = 1'b1;
                        end
                    end
                    else if ((pos_reg == '0) && (s_axis_tdata != HDR0))
                    begin
                        // Hunting for the first header byte: drop it.
                    end
                    else if ((pos_reg == POS_W'(1)) && (s_axis_tdata != HDR1))
                    begin
                        // Second header byte is wrong: restart the hunt.
                        pos_next = '0;
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = pos_reg;
                        mem_wr.data = s_axis_tdata;
                        if (pos_reg == '0)
                        begin
                            sum_next = SUM_INIT - {8'd0, s_axis_tdata};
                        end
                        else if (pos_reg < POS_W'(SUM_LEN))
                        begin
                            sum_next = sum_reg - {8'd0, s_axis_tdata};
                        end
                        if (pos_reg == SUM_LO_POS)
                        begin
                            sum_lo_next = s_axis_tdata;
                        end

                        if (pos_reg != LAST_POS)
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                        else
                        begin
                            pos_next = '0;
                            if ({s_axis_tdata, sum_lo_reg} != sum_reg)
                            begin
                                bad_sum_next   = bad_sum_reg + 32'd1;
                                out_load       = 1'b1;
                                out_res.status = ST_BAD_SUM;
                                out_res.last   = 1'b1;
                            end
                            else
                            begin
                                // Good frame: start reading channel 0.
                                sig_valid_next = 1'b1;
                                silence_next   = '0;
                                accepted_next  = accepted_reg + 32'd1;
                                ch_next        = '0;
                                mem_rd.en      = 1'b1;
                                mem_rd.addr_lo = CH_BASE;
                                mem_rd.addr_hi = CH_BASE + POS_W'(1);
                                state_next     = S_READ;
                            end
                        end
                    end
                end
            end

            S_READ:
            begin
                // Read data for ch_reg is ready; issue the next channel as this one leaves.
                if (slot_free)
                begin
                    out_load              = 1'b1;
                    out_res.status        = ST_CHANNEL;
                    out_res.channel_index = ch_reg;
                    out_res.channel_value = clamped[11:0];
                    out_res.last          = (ch_reg == LAST_CH);
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next        = ch_reg + 4'd1;
                        mem_rd.en      = 1'b1;
                        mem_rd.addr_lo = {ch_next, 1'b0} + CH_BASE;
                        mem_rd.addr_hi = {ch_next, 1'b0} + CH_BASE + POS_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every result carries the state after its input request.
        out_res.signal_ok         = sig_valid_next;
        out_res.frames_accepted   = accepted_next;
        out_res.checksum_failures = bad_sum_next;
        out_res.failsafe_events   = failsafe_next;
    end

    // Control and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            sum_reg       <= SUM_INIT;
            sig_valid_reg <= 1'b0;
            silence_reg   <= '0;
            accepted_reg  <= '0;
            bad_sum_reg   <= '0;
            failsafe_reg  <= '0;
            timeout_reg   <= TIMEOUT_RST;
            ch_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            sig_valid_reg <= sig_valid_next;
            silence_reg   <= silence_next;
            accepted_reg  <= accepted_next;
            bad_sum_reg   <= bad_sum_next;
            failsafe_reg  <= failsafe_next;
            timeout_reg   <= timeout_next;
            ch_reg        <= ch_next;
        end
    end

    // Low checksum byte is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        sum_lo_reg <= sum_lo_next;
    end

    // Result stream packing.
    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_data.status;
    assign m_axis_tlast  = out_data.last;
    assign m_axis_tdata  = {7'd0,
                            out_data.failsafe_events,
                            out_data.checksum_failures,
                            out_data.frames_accepted,
                            out_data.signal_ok,
                            out_data.channel_value,
                            out_data.channel_index};

endmodule

// ----- verif/rc_serial_frame_parser_core_tb.sv -----
// Self-checking testbench for rc_serial_frame_parser_core: serial bytes and ticks go in as
// requests, results are compared field by field against a frame parser predictor.
// Depends on rcfp_pkg and the rc_serial_frame_parser_core RTL.
module rc_serial_frame_parser_core_tb;
    import rcfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS       = 14;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 8;
    localparam int SEND_IDLE [4]  = '{0, 74, 0, 37};
    localparam int RECV_STALL [4] = '{0, 0, 74, 37};

    // One value per channel slot, around the clamp limits and the byte boundaries
    localparam logic [15:0] EDGE_VALUES [14] = '{
        16'd0, 16'd899, 16'd900, 16'd901, 16'd2099, 16'd2100, 16'd2101,
        16'hFFFF, 16'h0FFF, 16'h1000, 16'h8000, 16'h00FF, 16'h0100, 16'h7FFF
    };

    typedef enum int {ROW_BYTE, ROW_TICKS, ROW_FRAME, ROW_BAD_FRAME} row_kind_t;
    typedef enum int {FILL_LOW, FILL_HIGH, FILL_EDGE, FILL_RANDOM} fill_t;

    // One row of the directed plan; the exp_ fields hold a hand-written status result
    typedef struct {
        row_kind_t   kind;
        int          arg;
        fill_t       fill;
        bit          has_exp;
        status_t     exp_status;
        bit          exp_signal;
        logic [31:0] exp_frames;
        logic [31:0] exp_bad;
        logic [31:0] exp_trips;
    } row_t;

    logic         clk            = 1'b0;
    logic         rst_n          = 1'b0;
    logic         cfg_we         = 1'b0;
    logic [15:0]  cfg_wdata      = '0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata   = '0;
    logic         s_axis_tuser   = OP_BYTE;
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [119:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Predictor state
    logic [15:0] exp_timeout_ms = TIMEOUT_RST;
    logic [4:0]  exp_pos        = '0;
    logic [7:0]  exp_frame [FRAME_LEN] = '{default: 8'h00};
    logic [15:0] exp_sum        = SUM_INIT;
    logic        exp_link_ok    = 1'b0;
    logic [15:0] exp_silence    = '0;
    logic [31:0] exp_good       = '0;
    logic [31:0] exp_bad        = '0;
    logic [31:0] exp_trips      = '0;

    result_t pending_results [$];
    result_t fresh_results [$];
    result_t row_exp;
    bit      row_exp_armed  = 1'b0;
    int      taken_items    = 0;
    int      mismatches     = 0;
    int      idle_cycles    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    row_t directed_plan [13] = '{
        '{ROW_TICKS,     1,     FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h00, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'hFF, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h20, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h20, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h40, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h20, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BYTE,      8'h41, FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_FRAME,     0,     FILL_EDGE,   1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_TICKS,     2,     FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0},
        '{ROW_BAD_FRAME, 0,     FILL_HIGH,   1'b1, ST_BAD_SUM,  1'b1, 1, 1, 0},
        '{ROW_TICKS,     1,     FILL_LOW,    1'b1, ST_FAILSAFE, 1'b0, 1, 1, 1},
        '{ROW_TICKS,     1,     FILL_LOW,    1'b0, ST_CHANNEL,  1'b0, 0, 0, 0}
    };

    rc_serial_frame_parser_core #(
        .CHANNELS      (CHANNELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Builds a result from the current counters and link state
    function automatic result_t shape_result(input status_t st, input logic [3:0] idx,
                                             input logic [11:0] val, input logic fin);
        result_t r;
        r.status            = st;
        r.channel_index     = idx;
        r.channel_value     = val;
        r.last              = fin;
        r.signal_ok         = exp_link_ok;
        r.frames_accepted   = exp_good;
        r.checksum_failures = exp_bad;
        r.failsafe_events   = exp_trips;
        return r;
    endfunction

    // Frame parser predictor: advances the state for one request and leaves its
    // results in fresh_results.
    function automatic void parse_request(input logic op, input logic [7:0] rx);
        logic [15:0] raw;
        logic [15:0] got_sum;
        fresh_results.delete();
        taken_items++;
        if (op == OP_TICK)
        begin
            if (exp_silence != SILENCE_MAX)
                exp_silence++;
            if (exp_link_ok && exp_silence > exp_timeout_ms)
            begin
                exp_link_ok = 1'b0;
                exp_trips++;
                fresh_results.push_back(shape_result(ST_FAILSAFE, 4'd0, 12'd0, 1'b1));
            end
            return;
        end

        // Header hunt: a wrong second byte restarts the hunt without a recheck
        if (exp_pos == 5'd0 && rx != HDR0)
            return;
        if (exp_pos == 5'd1 && rx != HDR1)
        begin
            exp_pos = 5'd0;
            return;
        end

        exp_frame[exp_pos] = rx;
        if (exp_pos == 5'd0)
            exp_sum = SUM_INIT - rx;
        else if (exp_pos < SUM_LEN)
            exp_sum = exp_sum - rx;
        if (exp_pos != LAST_POS)
        begin
            exp_pos++;
            return;
        end

        exp_pos = 5'd0;
        got_sum = {exp_frame[LAST_POS], exp_frame[SUM_LO_POS]};
        if (got_sum != exp_sum)
        begin
            exp_bad++;
            fresh_results.push_back(shape_result(ST_BAD_SUM, 4'd0, 12'd0, 1'b1));
            return;
        end

        exp_link_ok = 1'b1;
        exp_silence = '0;
        exp_good++;
        for (int i = 0; i < CHANNELS; i++)
        begin
            raw = {exp_frame[CH_BASE + 2 * i + 1], exp_frame[CH_BASE + 2 * i]};
            if (raw < CH_MIN)
                raw = CH_MIN;
            if (raw > CH_MAX)
                raw = CH_MAX;
            fresh_results.push_back(shape_result(ST_CHANNEL, 4'(i), raw[11:0],
                                                 i == CHANNELS - 1));
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Both handshakes are sampled mid-cycle, where every signal is settled; a
    // request seen here completes at the next rising edge.
    always @(negedge clk)
    begin : monitor
        result_t want;
        if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
        begin
            parse_request(s_axis_tuser, s_axis_tdata);
            // A hand-written status result stands in for the predicted one
            if (row_exp_armed && fresh_results.size() != 0)
            begin
                fresh_results.delete();
                fresh_results.push_back(row_exp);
                row_exp_armed = 1'b0;
            end
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
        end

        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, m_axis_tuser);
                compare_field("channel_index", want.channel_index, m_axis_tdata[3:0]);
                compare_field("channel_value", want.channel_value, m_axis_tdata[15:4]);
                compare_field("signal_ok", want.signal_ok, m_axis_tdata[16]);
                compare_field("frames_accepted", want.frames_accepted, m_axis_tdata[48:17]);
                compare_field("checksum_failures", want.checksum_failures,
                              m_axis_tdata[80:49]);
                compare_field("failsafe_events", want.failsafe_events, m_axis_tdata[112:81]);
                compare_field("padding", '0, m_axis_tdata[119:113]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end

        // Watchdog on cycles without any handshake on either stream
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            || (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rc_serial_frame_parser_core_tb NOT OK");
            $finish;
        end
    end

    // Offers one request after a random gap and returns at the edge that takes it.
    // Called right after a rising edge; valid stays high for a following request.
    task automatic issue_request(input logic op, input logic [7:0] data);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do
        begin
            @(negedge clk);
            taken = (s_axis_tready === 1'b1);
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            issue_request(OP_TICK, 8'($urandom_range(255)));
    endtask

    // Builds a frame with a matching or a broken checksum and sends its first nbytes
    // bytes, with ticks scattered in between.
    task automatic send_frame(input fill_t fill, input bit corrupt, input int nbytes,
                              input int tick_pct);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] word;
        logic [15:0] check;
        int          roll;
        frame[0] = HDR0;
        frame[1] = HDR1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            roll = $urandom_range(99);
            case (fill)
                FILL_LOW:  word = 16'h0000;
                FILL_HIGH: word = 16'hFFFF;
                FILL_EDGE: word = EDGE_VALUES[i];
                default:
                    if (roll < 40)
                        word = 16'($urandom_range(CH_MAX, CH_MIN));
                    else if (roll < 60)
                        word = EDGE_VALUES[$urandom_range(13)];
                    else
                        word = 16'($urandom_range(16'hFFFF));
            endcase
            frame[CH_BASE + 2 * i]     = word[7:0];
            frame[CH_BASE + 2 * i + 1] = word[15:8];
        end
        check = SUM_INIT;
        for (int k = 0; k < SUM_LEN; k++)
            check = check - frame[k];
        if (corrupt)
            check = check + 16'($urandom_range(1, 65535));
        frame[SUM_LO_POS] = check[7:0];
        frame[LAST_POS]   = check[15:8];
        for (int k = 0; k < nbytes; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_ticks(1);
            issue_request(OP_BYTE, frame[k]);
        end
    endtask

    // Waits until every expected result is out and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        settle();
        cfg_we         <= 1'b1;
        cfg_wdata      <= value;
        exp_timeout_ms = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        row_t row;
        int   start_items;
        int   pick;
        int   count;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan at a short timeout, so that failsafe is reached in a few ticks
        write_timeout(16'd2);
        foreach (directed_plan[r])
        begin
            row = directed_plan[r];
            if (row.has_exp)
            begin
                row_exp = '{status: row.exp_status, channel_index: 4'd0,
                            channel_value: 12'd0, last: 1'b1, signal_ok: row.exp_signal,
                            frames_accepted: row.exp_frames, checksum_failures: row.exp_bad,
                            failsafe_events: row.exp_trips};
                row_exp_armed = 1'b1;
            end
            case (row.kind)
                ROW_BYTE:      issue_request(OP_BYTE, 8'(row.arg));
                ROW_TICKS:     send_ticks(row.arg);
                ROW_FRAME:     send_frame(row.fill, 1'b0, FRAME_LEN, 0);
                ROW_BAD_FRAME: send_frame(row.fill, 1'b1, FRAME_LEN, 0);
                default:       ;
            endcase
            // A status result the predictor did not produce is still owed
            if (row_exp_armed)
            begin
                pending_results.push_back(row_exp);
                row_exp_armed = 1'b0;
            end
        end

        // Random phases, each with its own timeout and idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_timeout(16'hFFFF);
                1:       write_timeout(16'd1);
                2:       write_timeout(16'd0);
                default: write_timeout(16'($urandom_range(2, 60)));
            endcase
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];

            start_items = taken_items;
            while (taken_items - start_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    send_frame(FILL_RANDOM, 1'b0, FRAME_LEN, 5);
                else if (pick < 60)
                    send_frame(FILL_RANDOM, 1'b1, FRAME_LEN, 5);
                else if (pick < 65)
                    send_frame(FILL_RANDOM, 1'b0, $urandom_range(2, FRAME_LEN - 1), 0);
                else if (pick < 72)
                begin
                    repeat ($urandom_range(1, 6))
                        issue_request(OP_BYTE, 8'($urandom_range(255)));
                end
                else if (pick < 77)
                begin
                    // First header byte followed by a wrong second one
                    issue_request(OP_BYTE, HDR0);
                    count = $urandom_range(255);
                    issue_request(OP_BYTE, (8'(count) == HDR1) ? HDR0 : 8'(count));
                end
                else
                begin
                    if ($urandom_range(99) < 70)
                        count = $urandom_range(1, 4);
                    else if (exp_timeout_ms < 64)
                        count = exp_timeout_ms + 2;
                    else
                        count = $urandom_range(5, 40);
                    send_ticks(count);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("rc_serial_frame_parser_core_tb OK");
        else
            $display("rc_serial_frame_parser_core_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rcfp_pkg.sv
hw/rtl/rcfp_frame_mem.sv
hw/rtl/rcfp_out_stage.sv
hw/rtl/rc_serial_frame_parser_core.sv
verif/rc_serial_frame_parser_core_tb.sv
